[hdl/nspc_pkg.sv]
// nspc_pkg: shared types and constants of the scan probe classifier
// no dependencies

package nspc_pkg;

    localparam logic [1:0] KIND_HORIZONTAL   = 2'd0;
    localparam logic [1:0] KIND_VERTICAL     = 2'd1;
    localparam logic [1:0] KIND_STROBE       = 2'd2;
    localparam logic [1:0] KIND_UNCLASSIFIED = 2'd3;

    localparam logic [1:0] CFG_REPEAT_THRESHOLD    = 2'd0;
    localparam logic [1:0] CFG_MIN_PACKETS_KEPT    = 2'd1;
    localparam logic [1:0] CFG_COMPACTION_INTERVAL = 2'd2;

    localparam int STAMP_W = 52;

    // one table record
    typedef struct packed {
        logic [31:0]        source;
        logic [31:0]        dest;
        logic [15:0]        port;
        logic [31:0]        count;
        logic [1:0]         kind;
        logic [STAMP_W-1:0] first_time;
        logic [STAMP_W-1:0] last_time;
    } record_t;

    // update of a record for a packet of a known source
    function automatic record_t touch_record(input record_t r, input logic [31:0] dst,
                                             input logic [15:0] port,
                                             input logic [STAMP_W-1:0] stamp);
        record_t o;
        logic    new_dst;
        logic    new_port;
        o        = r;
        new_dst  = (r.dest != dst);
        new_port = (r.port != port);
        if (r.count != 32'hFFFF_FFFF)
            o.count = r.count + 32'd1;
        o.last_time = stamp;
        if (new_dst && new_port)
            o.kind = KIND_STROBE;
        else if (r.kind != KIND_STROBE)
        begin
            if (new_port)
                o.kind = KIND_VERTICAL;
            else if (new_dst)
                o.kind = KIND_HORIZONTAL;
        end
        return o;
    endfunction

endpackage

[hdl/nspc_ring.sv]
// nspc_ring: ring of recent source addresses with parallel hit count
// depends on nothing outside this file

module nspc_ring #(
    parameter int RING_DEPTH = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [31:0]                   src,
    output logic [$clog2(RING_DEPTH+1)-1:0] hits
);
    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int HW = $clog2(RING_DEPTH+1);

    logic [31:0]   ring_reg [RING_DEPTH];
    logic [PW-1:0] pos_reg;

    always_comb
    begin
        hits = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            hits = hits + HW'(ring_reg[i] == src);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else if (push)
        begin
            ring_reg[pos_reg] <= src;
            pos_reg <= (pos_reg == PW'(RING_DEPTH-1)) ? '0 : pos_reg + PW'(1);
        end
    end
endmodule

[hdl/nspc_table.sv]
// nspc_table: record memory, one synchronous read and one write port
// depends on nspc_pkg

module nspc_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int AW = 8
) (
    input  logic              clk,
    input  logic [AW-1:0]     rd_addr,
    output nspc_pkg::record_t rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  nspc_pkg::record_t wr_data
);
    nspc_pkg::record_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

[hdl/network_scan_probe_classifier.sv]
// network_scan_probe_classifier: top level, control sequencer
// depends on nspc_pkg, nspc_ring, nspc_table

// One packet word at a time. The ring compare is done in the accepting cycle.
// A suspect then scans the record memory entry by entry, issuing the read of
// each entry and then comparing the read data. When the compaction interval
// is reached the memory is swept once more, reading each record and writing
// survivors to the next free slot. The result word is held in an output
// register; a new input word is taken once the previous result is out. No
// clearing pass is needed after reset: only slots below the fill count are
// read.
module network_scan_probe_classifier #(
    parameter int TABLE_DEPTH    = 256,
    parameter int RING_DEPTH     = 15,
    parameter int WARMUP_PACKETS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [15:0] dest_port,
    input  logic [31:0] time_seconds,
    input  logic [19:0] time_micros,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_suspect,
    output logic [7:0]  entry_index,
    output logic        new_entry,
    output logic [31:0] entry_packets,
    output logic [1:0]  probe_type,
    output logic        table_full_drop,
    output logic        compacted,
    output logic [8:0]  entries_in_use
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH+1);
    localparam int WW = $clog2(WARMUP_PACKETS+2);
    localparam int HW = $clog2(RING_DEPTH+1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;   // read slot issued
    localparam logic [2:0] ST_CHK   = 3'd2;   // compare read data
    localparam logic [2:0] ST_CMP   = 3'd3;   // compaction read issued
    localparam logic [2:0] ST_CMPW  = 3'd4;   // compaction decide and write
    localparam logic [2:0] ST_OUT   = 3'd5;   // result waits in output register

    logic [2:0]  state_reg, state_next;

    // configuration
    logic [3:0]  thr_reg;
    logic [7:0]  minp_reg;
    logic [23:0] intv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 4'd3;
            minp_reg <= 8'd5;
            intv_reg <= 24'd1000000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nspc_pkg::CFG_REPEAT_THRESHOLD:    thr_reg  <= cfg_data[3:0];
                nspc_pkg::CFG_MIN_PACKETS_KEPT:    minp_reg <= cfg_data[7:0];
                nspc_pkg::CFG_COMPACTION_INTERVAL: intv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // counters
    logic [WW-1:0] warm_reg;
    logic [23:0]   since_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] kept_reg;

    // held packet
    logic [31:0] src_reg, dst_reg;
    logic [15:0] port_reg;
    logic [nspc_pkg::STAMP_W-1:0] stamp_reg;
    logic        do_compact_reg;

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // ring
    logic [HW-1:0] hits;
    logic [WW-1:0] warm_inc;
    logic          suspect_now;
    assign warm_inc    = (warm_reg <= WW'(WARMUP_PACKETS)) ? warm_reg + WW'(1) : warm_reg;
    assign suspect_now = (warm_inc > WW'(WARMUP_PACKETS)) && (32'(hits) > 32'(thr_reg));

    nspc_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .src   (source_address),
        .hits  (hits)
    );

    // record memory
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              wr_en;
    nspc_pkg::record_t rd_data, wr_data, upd;

    // second write source uses the same port; search states never overlap
    logic              wr_en_f;
    logic [AW-1:0]     wr_addr_f;
    nspc_pkg::record_t wr_data_f;

    nspc_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en_f),
        .wr_addr (wr_addr_f),
        .wr_data (wr_data_f)
    );

    assign upd = nspc_pkg::touch_record(rd_data, dst_reg, port_reg, stamp_reg);

    logic [23:0] since_inc;
    assign since_inc = since_reg + 24'd1;

    logic keep;
    assign keep = (rd_data.count > 32'(minp_reg)) &&
                  (rd_data.kind != nspc_pkg::KIND_UNCLASSIFIED);

    // result register
    logic        o_susp_reg, o_new_reg, o_drop_reg, o_cmp_reg;
    logic [7:0]  o_idx_reg;
    logic [31:0] o_pk_reg;
    logic [1:0]  o_kind_reg;

    logic [CW-1:0] idx_next, kept_next, used_next;

    // read address follows the scan index
    assign rd_addr = idx_next[AW-1:0];

    // write request: search update or compaction move; new records are merged below
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = upd;
        if (state_reg == ST_CHK)
        begin
            if (rd_data.source == src_reg)
                wr_en = 1'b1;
        end
        else if (state_reg == ST_CMPW)
        begin
            wr_en   = keep;
            wr_addr = kept_reg[AW-1:0];
            wr_data = rd_data;
        end
    end

    // new record when search ran off the end
    nspc_pkg::record_t fresh;
    always_comb
    begin
        fresh.source     = src_reg;
        fresh.dest       = dst_reg;
        fresh.port       = port_reg;
        fresh.count      = 32'd1;
        fresh.kind       = nspc_pkg::KIND_UNCLASSIFIED;
        fresh.first_time = stamp_reg;
        fresh.last_time  = stamp_reg;
    end

    logic new_wr;
    assign new_wr = (state_reg == ST_SRCH) && (idx_reg == used_reg) &&
                    (used_reg != CW'(TABLE_DEPTH));

    always_comb
    begin
        wr_en_f   = wr_en || new_wr;
        wr_addr_f = new_wr ? used_reg[AW-1:0] : wr_addr;
        wr_data_f = new_wr ? fresh : wr_data;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        kept_next  = kept_reg;
        used_next  = used_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    if (suspect_now)
                        state_next = ST_SRCH;
                    else if (since_inc == intv_reg)
                    begin
                        state_next = ST_CMP;
                        kept_next  = '0;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SRCH:
            begin
                if (idx_reg == used_reg)
                begin
                    if (used_reg != CW'(TABLE_DEPTH))
                        used_next = used_reg + CW'(1);
                    if (do_compact_reg)
                    begin
                        state_next = ST_CMP;
                        idx_next   = '0;
                        kept_next  = '0;
                    end
                    else
                        state_next = ST_OUT;
                end
                else
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (rd_data.source == src_reg)
                begin
                    if (do_compact_reg)
                    begin
                        state_next = ST_CMP;
                        idx_next   = '0;
                        kept_next  = '0;
                    end
                    else
                        state_next = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_SRCH;
                end
            end
            ST_CMP:
            begin
                if (idx_reg == used_reg)
                begin
                    used_next  = kept_reg;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_CMPW;
            end
            ST_CMPW:
            begin
                if (keep)
                    kept_next = kept_reg + CW'(1);
                idx_next   = idx_reg + CW'(1);
                state_next = ST_CMP;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            warm_reg       <= '0;
            since_reg      <= '0;
            used_reg       <= '0;
            idx_reg        <= '0;
            kept_reg       <= '0;
            do_compact_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            kept_reg  <= kept_next;
            used_reg  <= used_next;
            if (accept)
            begin
                warm_reg       <= warm_inc;
                do_compact_reg <= (since_inc == intv_reg);
                since_reg      <= (since_inc == intv_reg) ? 24'd0 : since_inc;
            end
        end
    end

    // payload and result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg    <= source_address;
            dst_reg    <= dest_address;
            port_reg   <= dest_port;
            stamp_reg  <= {time_seconds, time_micros};
            o_susp_reg <= suspect_now;
            o_new_reg  <= 1'b0;
            o_drop_reg <= 1'b0;
            o_cmp_reg  <= (since_inc == intv_reg);
            o_idx_reg  <= '0;
            o_pk_reg   <= '0;
            o_kind_reg <= nspc_pkg::KIND_UNCLASSIFIED;
        end
        else if (state_reg == ST_SRCH && idx_reg == used_reg)
        begin
            if (used_reg != CW'(TABLE_DEPTH))
            begin
                o_new_reg  <= 1'b1;
                o_idx_reg  <= 8'(used_reg);
                o_pk_reg   <= 32'd1;
                o_kind_reg <= nspc_pkg::KIND_UNCLASSIFIED;
            end
            else
                o_drop_reg <= 1'b1;
        end
        else if (state_reg == ST_CHK && rd_data.source == src_reg)
        begin
            o_idx_reg  <= 8'(idx_reg);
            o_pk_reg   <= upd.count;
            o_kind_reg <= upd.kind;
        end
    end

    assign out_valid       = (state_reg == ST_OUT);
    assign is_suspect      = o_susp_reg;
    assign entry_index     = o_idx_reg;
    assign new_entry       = o_new_reg;
    assign entry_packets   = o_pk_reg;
    assign probe_type      = o_kind_reg;
    assign table_full_drop = o_drop_reg;
    assign compacted       = o_cmp_reg;
    assign entries_in_use  = 9'(used_reg);

    // a result never claims both a new record and a drop
    a_new_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(new_entry && table_full_drop))
        else $error("new record and drop in one result");

    // the fill count never exceeds the table
    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // compaction never grows the table
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && idx_reg == used_reg) |=> used_reg <= $past(used_reg))
        else $error("compaction grew the table");
endmodule
